// ===== src/m2i_pkg.sv =====
// shared types, constants and arithmetic helpers for the 2x2 matrix inverse core
package m2i_pkg;

  localparam int ELEM_W = 32;
  localparam int PROD_W = 64;
  localparam int Q_W    = 33;
  localparam int NLANE  = 4;

  localparam logic [PROD_W:0] POS_LIM = (PROD_W+1)'(64'h0000_0000_7FFF_FFFF);
  localparam logic [PROD_W:0] NEG_LIM = (PROD_W+1)'(64'h0000_0000_8000_0000);

  // one adjugate element on its way through the divider
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [ELEM_W-1:0] num;
    logic [Q_W-1:0]    q;
    logic              big;
    logic              neg;
  } lane_t;

  // per-item data shared by all lanes
  typedef struct packed {
    logic [PROD_W-1:0] den;
    logic              sing;
    logic [ELEM_W-1:0] det_out;
    logic              det_ovf;
  } side_t;

  // rounded quotient magnitude
  typedef struct packed {
    logic [Q_W:0] qr;
    logic         big;
    logic         neg;
  } fin_t;

  typedef struct packed {
    logic              ovf;
    logic [ELEM_W-1:0] val;
  } res_t;

  // one restoring step: bring in the next dividend bit, trial subtract
  function automatic lane_t div_step(lane_t l, logic [PROD_W-1:0] den);
    logic [PROD_W:0] sh;
    logic            ge;
    lane_t           o;
    sh = {l.rem, l.num[ELEM_W-1]};
    ge = (sh >= {1'b0, den});
    o = l;
    o.rem = ge ? PROD_W'(sh - {1'b0, den}) : sh[PROD_W-1:0];
    o.num = {l.num[ELEM_W-2:0], 1'b0};
    o.big = l.big | l.q[Q_W-1];
    o.q   = {l.q[Q_W-2:0], ge};
    return o;
  endfunction

  // apply sign and saturate a magnitude to 32 bits
  function automatic res_t pack_mag(logic [PROD_W:0] m, logic big, logic neg);
    res_t r;
    if (neg) begin
      r.ovf = big | (m > NEG_LIM);
      r.val = r.ovf ? NEG_LIM[ELEM_W-1:0] : ELEM_W'(0 - m[ELEM_W-1:0]);
    end else begin
      r.ovf = big | (m > POS_LIM);
      r.val = r.ovf ? POS_LIM[ELEM_W-1:0] : m[ELEM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/matrix2x2_inverse_core.sv =====
// 2x2 matrix inverse with determinant, fully pipelined
//
//   channel  direction  ports
//   in       input      in_valid, in_stall, in_elem_11/12/21/22 (signed Q16.16)
//   out      output     out_valid, out_stall, out_inv_11/12/21/22, out_det_value,
//                       out_singular, out_overflow
//
// one item enters per cycle while out_stall does not freeze the pipeline;
// the divider is a bit-per-stage restoring divider, one stage per quotient bit.
// the stages before it form the products, the determinant and its magnitude,
// the two after it round and saturate.
// rst_n clears the valid bits only; payload registers are not reset.
// out_stall with a valid result freezes every stage, and in_stall follows it.
module matrix2x2_inverse_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_elem_11,
  input  logic signed [31:0] in_elem_12,
  input  logic signed [31:0] in_elem_21,
  input  logic signed [31:0] in_elem_22,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_inv_11,
  output logic signed [31:0] out_inv_12,
  output logic signed [31:0] out_inv_21,
  output logic signed [31:0] out_inv_22,
  output logic signed [31:0] out_det_value,
  output logic        out_singular,
  output logic        out_overflow
);

  localparam int NB  = 2 * FRAC_BITS + m2i_pkg::ELEM_W;
  localparam int PW  = m2i_pkg::PROD_W;
  localparam int EW  = m2i_pkg::ELEM_W;
  localparam logic [PW:0] DET_HALF = (PW+1)'(1) << (FRAC_BITS - 1);

  logic en;

  // stage a: products
  logic                 a_vld_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic signed [EW-1:0] a_adj_r [m2i_pkg::NLANE];
  // stage b: determinant
  logic                 b_vld_r;
  logic signed [PW-1:0] det_r;
  logic signed [EW-1:0] b_adj_r [m2i_pkg::NLANE];
  // stage c: magnitudes and signs
  logic                 c_vld_r;
  logic [PW-1:0]        c_dmag_r;
  logic                 c_dneg_r;
  logic                 c_sing_r;
  m2i_pkg::lane_t       c_lane_r [m2i_pkg::NLANE];
  // divider stages
  logic                 d_vld_r  [NB];
  m2i_pkg::side_t       d_side_r [NB];
  m2i_pkg::lane_t       d_lane_r [NB][m2i_pkg::NLANE];
  // rounding stage
  logic                 r_vld_r;
  m2i_pkg::side_t       r_side_r;
  m2i_pkg::fin_t        r_fin_r  [m2i_pkg::NLANE];
  // output register
  logic                 o_vld_r;
  logic [EW-1:0]        o_inv_r  [m2i_pkg::NLANE];
  logic [EW-1:0]        o_det_r;
  logic                 o_sing_r;
  logic                 o_ovf_r;

  assign en       = ~(o_vld_r & out_stall);
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      r_vld_r <= d_vld_r[NB-1];
      o_vld_r <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r       <= in_elem_11 * in_elem_22;
      p2_r       <= in_elem_12 * in_elem_21;
      // adjugate order: a22, -a12, -a21, a11 (negation folded into the sign below)
      a_adj_r[0] <= in_elem_22;
      a_adj_r[1] <= in_elem_12;
      a_adj_r[2] <= in_elem_21;
      a_adj_r[3] <= in_elem_11;
      det_r      <= p1_r - p2_r;
      b_adj_r    <= a_adj_r;
    end
  end

  // stage c
  always_ff @(posedge clk) begin
    if (en) begin
      c_dneg_r <= det_r[PW-1];
      c_dmag_r <= det_r[PW-1] ? PW'(-det_r) : PW'(det_r);
      c_sing_r <= (det_r == '0);
      for (int i = 0; i < m2i_pkg::NLANE; i++) begin
        c_lane_r[i].rem <= '0;
        c_lane_r[i].q   <= '0;
        c_lane_r[i].big <= 1'b0;
        c_lane_r[i].num <= b_adj_r[i][EW-1] ? EW'(-b_adj_r[i]) : EW'(b_adj_r[i]);
        if (i == 1 || i == 2) begin
          c_lane_r[i].neg <= (b_adj_r[i] > 0) ^ det_r[PW-1];
        end else begin
          c_lane_r[i].neg <= b_adj_r[i][EW-1] ^ det_r[PW-1];
        end
      end
    end
  end

  // determinant rounding, done on entry to the divider
  logic [PW:0]    det_sum;
  logic [PW:0]    det_dm;
  m2i_pkg::res_t  det_res;
  m2i_pkg::side_t side0;

  always_comb begin
    det_sum       = {1'b0, c_dmag_r} + DET_HALF;
    det_dm        = det_sum >> FRAC_BITS;
    det_res       = m2i_pkg::pack_mag(det_dm, 1'b0, c_dneg_r);
    side0.den     = c_dmag_r;
    side0.sing    = c_sing_r;
    side0.det_out = det_res.val;
    side0.det_ovf = det_res.ovf;
  end

  genvar k, j;
  generate
    for (k = 0; k < NB; k++) begin : g_div
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            d_vld_r[k] <= 1'b0;
          end else if (en) begin
            d_vld_r[k] <= c_vld_r;
          end
        end
        always_ff @(posedge clk) begin
          if (en) begin
            d_side_r[k] <= side0;
          end
        end
        for (j = 0; j < m2i_pkg::NLANE; j++) begin : g_lane
          always_ff @(posedge clk) begin
            if (en) begin
              d_lane_r[k][j] <= m2i_pkg::div_step(c_lane_r[j], c_dmag_r);
            end
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            d_vld_r[k] <= 1'b0;
          end else if (en) begin
            d_vld_r[k] <= d_vld_r[k-1];
          end
        end
        always_ff @(posedge clk) begin
          if (en) begin
            d_side_r[k] <= d_side_r[k-1];
          end
        end
        for (j = 0; j < m2i_pkg::NLANE; j++) begin : g_lane
          always_ff @(posedge clk) begin
            if (en) begin
              d_lane_r[k][j] <= m2i_pkg::div_step(d_lane_r[k-1][j], d_side_r[k-1].den);
            end
          end
        end
      end
    end
  endgenerate

  // round to nearest, ties away: bump when twice the remainder reaches the divisor
  m2i_pkg::fin_t fin_nxt [m2i_pkg::NLANE];

  always_comb begin
    for (int i = 0; i < m2i_pkg::NLANE; i++) begin
      fin_nxt[i].qr  = {1'b0, d_lane_r[NB-1][i].q} +
                       (m2i_pkg::Q_W+1)'({d_lane_r[NB-1][i].rem, 1'b0} >=
                                         {1'b0, d_side_r[NB-1].den});
      fin_nxt[i].big = d_lane_r[NB-1][i].big;
      fin_nxt[i].neg = d_lane_r[NB-1][i].neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_side_r <= d_side_r[NB-1];
      r_fin_r  <= fin_nxt;
    end
  end

  // saturation and singular masking
  m2i_pkg::res_t inv_res [m2i_pkg::NLANE];
  logic          inv_ovf;

  always_comb begin
    inv_ovf = 1'b0;
    for (int i = 0; i < m2i_pkg::NLANE; i++) begin
      inv_res[i] = m2i_pkg::pack_mag((PW+1)'(r_fin_r[i].qr), r_fin_r[i].big,
                                     r_fin_r[i].neg);
      inv_ovf    = inv_ovf | inv_res[i].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < m2i_pkg::NLANE; i++) begin
        o_inv_r[i] <= r_side_r.sing ? '0 : inv_res[i].val;
      end
      o_det_r  <= r_side_r.sing ? '0 : r_side_r.det_out;
      o_sing_r <= r_side_r.sing;
      o_ovf_r  <= ~r_side_r.sing & (inv_ovf | r_side_r.det_ovf);
    end
  end

  assign out_valid     = o_vld_r;
  assign out_inv_11    = o_inv_r[0];
  assign out_inv_12    = o_inv_r[1];
  assign out_inv_21    = o_inv_r[2];
  assign out_inv_22    = o_inv_r[3];
  assign out_det_value = o_det_r;
  assign out_singular  = o_sing_r;
  assign out_overflow  = o_ovf_r;

endmodule
